[rtl/tlvp_pkg.sv]
// Shared types, constants and the element-code lookup for the TLV parser.
// No dependencies.
`default_nettype none

package tlvp_pkg;

	localparam int MSG_BYTES = 4096;
	localparam int HDR_BYTES = 2;
	localparam int POS_W     = 12;
	localparam int POS_MAX   = ((MSG_BYTES - 1) < 4095) ? (MSG_BYTES - 1) : 4095;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 72;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// parse phase, one-hot
	typedef enum logic [2:0] {
		PH_TYPE  = 3'b001,
		PH_LEN   = 3'b010,
		PH_VALUE = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		K_TEXT    = 3'd0,
		K_INT     = 3'd1,
		K_SHORT   = 3'd2,
		K_BYTE    = 3'd3,
		K_FLAG    = 3'd4,
		K_ADDR    = 3'd5,
		K_UNKNOWN = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ES_OK      = 2'd0,
		ES_BAD_LEN = 2'd1,
		ES_UNKNOWN = 2'd2
	} elem_status_t;

	typedef enum logic [1:0] {
		MS_OK      = 2'd0,
		MS_OVERRUN = 2'd1,
		MS_STRAY   = 2'd2
	} msg_status_t;

	// one result word as it sits in the output queue
	typedef struct packed {
		logic                  last;
		logic                  user;
		logic [OUT_DATA_W-1:0] data;
	} out_word_t;

	function automatic kind_t kind_of(input logic [7:0] code);
		kind_t k;
		case (code)
			8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd10, 8'd13,
			8'd15, 8'd16, 8'd17, 8'd22, 8'd28:               k = K_TEXT;
			8'd8, 8'd9, 8'd27, 8'd31:                        k = K_INT;
			8'd11, 8'd12, 8'd14, 8'd19, 8'd20, 8'd21, 8'd24: k = K_SHORT;
			8'd23:                                           k = K_BYTE;
			8'd25, 8'd26:                                    k = K_FLAG;
			8'd18:                                           k = K_ADDR;
			default:                                         k = K_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

[rtl/tlv_info_element_parser.sv]
// Information-element TLV parser: phase machine, element checks, result queue.
// Depends on tlvp_pkg.
`default_nettype none

// A result word is registered into the result queue with the byte that completes it.
// Throughput: one byte per cycle; s_tready drops only when the 4-entry result
// queue has fewer than two free slots (a final byte can yield two words).
// Reset: arst_n clears the phase machine, offsets and queue asynchronously;
// the parser also rearms itself after every byte flagged with s_tlast.
module tlv_info_element_parser
	import tlvp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // data_byte[7:0]
	input  wire logic                  s_tlast,   // msg_last
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// ie_code[7:0], ie_length[15:8], value_offset[27:16], value_kind[30:28],
	// number_value[62:31], elem_status[64:63], msg_status[66:65], zero pad
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tuser,   // is_summary
	output logic                       m_tlast    // last_of_run
);

	// parser state
	phase_t             phase_q;
	logic [7:0]         code_q;
	logic [7:0]         len_q;
	logic [7:0]         remain_q;
	logic [31:0]        acc_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   start_q;

	phase_t             phase_d;
	logic [7:0]         code_d;
	logic [7:0]         len_d;
	logic [7:0]         remain_d;
	logic [31:0]        acc_d;
	logic [POS_W-1:0]   pos_d;
	logic [POS_W-1:0]   start_d;

	// output queue
	out_word_t          fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               accept;
	logic               pop;
	logic               elem_v;     // element word produced by this byte
	logic               sum_v;      // summary word produced by this byte
	logic               done;       // element completed on this byte
	msg_status_t        mstat;

	logic [7:0]         el_len;     // length seen by the element checks
	logic [31:0]        el_acc;     // value seen by the element checks
	kind_t              kind;
	elem_status_t       estat;
	logic [2:0]         need;       // value bytes a numeric kind requires
	logic [POS_W:0]     off_sum;
	logic [POS_W-1:0]   off;
	logic [31:0]        num;
	logic [7:0]         rem_dec;

	out_word_t          elem_word;
	out_word_t          sum_word;
	out_word_t          first_word;
	logic [1:0]         n_push;

	assign accept   = s_tvalid & s_tready;
	assign pop      = m_tvalid & m_tready;
	assign s_tready = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
	assign rem_dec  = remain_q - 8'd1;

	// Phase machine. Length and accumulator feed the element checks as they
	// stand after this byte, before the end-of-message rearm clears them.
	always_comb begin
		phase_d  = phase_q;
		code_d   = code_q;
		len_d    = len_q;
		remain_d = remain_q;
		acc_d    = acc_q;
		start_d  = start_q;
		pos_d    = pos_q;
		elem_v   = 1'b0;
		sum_v    = 1'b0;
		done     = 1'b0;
		mstat    = MS_OK;
		case (phase_q)
			PH_LEN: begin
				len_d    = s_tdata;
				remain_d = s_tdata;
				if (s_tdata == 8'd0) begin
					elem_v  = 1'b1;
					done    = 1'b1;
					phase_d = PH_TYPE;
				end else begin
					phase_d = PH_VALUE;
				end
			end
			PH_VALUE: begin
				acc_d    = {acc_q[23:0], s_tdata};
				remain_d = rem_dec;
				if (rem_dec == 8'd0) begin
					elem_v  = 1'b1;
					done    = 1'b1;
					phase_d = PH_TYPE;
				end
			end
			default: begin
				// expecting a type byte; an illegal phase code lands here too
				code_d   = s_tdata;
				len_d    = 8'd0;
				remain_d = 8'd0;
				acc_d    = 32'd0;
				start_d  = pos_q;
				phase_d  = PH_LEN;
				if (s_tlast) begin
					sum_v = 1'b1;
					mstat = MS_STRAY;
				end
			end
		endcase

		el_len = len_d;
		el_acc = acc_d;

		if (s_tlast) begin
			// message ends: summary unless the stray-byte one is already out
			if (!sum_v) begin
				sum_v = 1'b1;
				mstat = done ? MS_OK : MS_OVERRUN;
			end
			phase_d  = PH_TYPE;
			code_d   = 8'd0;
			len_d    = 8'd0;
			remain_d = 8'd0;
			acc_d    = 32'd0;
			start_d  = '0;
			pos_d    = '0;
		end else if (pos_q < POS_W'(POS_MAX)) begin
			pos_d = pos_q + POS_W'(1);
		end
	end

	// element checks on the updated length and value
	always_comb begin
		kind = kind_of(code_q);
		case (kind)
			K_INT:   need = 3'd4;
			K_SHORT: need = 3'd2;
			K_BYTE:  need = 3'd1;
			default: need = 3'd0;
		endcase
		if (kind == K_UNKNOWN)
			estat = ES_UNKNOWN;
		else if (need != 3'd0 && el_len != {5'd0, need})
			estat = ES_BAD_LEN;
		else
			estat = ES_OK;
		num = (need != 3'd0 && estat == ES_OK) ? el_acc : 32'd0;
		// value offset saturates with the byte counter
		off_sum = {1'b0, start_q} + (POS_W+1)'(HDR_BYTES);
		off = (off_sum > (POS_W+1)'(POS_MAX)) ? POS_W'(POS_MAX) : off_sum[POS_W-1:0];
	end

	always_comb begin
		elem_word.last = 1'b0;
		elem_word.user = 1'b0;
		elem_word.data = {5'd0, MS_OK, estat, num, kind, off, el_len, code_q};
		sum_word.last  = 1'b1;
		sum_word.user  = 1'b1;
		sum_word.data  = {5'd0, mstat, 65'd0};
		first_word     = elem_v ? elem_word : sum_word;
		n_push         = accept ? ({1'b0, elem_v} + {1'b0, sum_v}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			code_q   <= 8'd0;
			len_q    <= 8'd0;
			remain_q <= 8'd0;
			acc_q    <= 32'd0;
			pos_q    <= '0;
			start_q  <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			code_q   <= code_d;
			len_q    <= len_d;
			remain_q <= remain_d;
			acc_q    <= acc_d;
			pos_q    <= pos_d;
			start_q  <= start_d;
		end
	end

	// Result queue: up to two words in per byte, one word out per cycle while m_tready is high.
	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			fifo_q[wr_q] <= first_word;
		if (n_push == 2'd2)
			fifo_q[wr_q + PTR_W'(1)] <= sum_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(n_push);
			if (pop)
				rd_q <= rd_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = fifo_q[rd_q].data;
	assign m_tuser  = fifo_q[rd_q].user;
	assign m_tlast  = fifo_q[rd_q].last;

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for tlv_info_element_parser: streams messages of TLV elements
// in and checks every result word against an in-bench model of the parser.
// Depends on tlvp_pkg and the parser RTL.

module tb;
	import tlvp_pkg::*;

	localparam int MAX_WAIT     = 17;
	localparam int RANDOM_ITEMS = 860;
	localparam int IDLE_LIMIT   = 1000;   // cycles with no word moving on either side
	localparam int MAX_ERR_LINES = 30;

	// one expected result word, field by field
	typedef struct {
		logic         summary;
		logic [7:0]   code;
		logic [7:0]   len;
		logic [11:0]  offset;
		kind_t        kind;
		logic [31:0]  num;
		elem_status_t es;
		msg_status_t  ms;
		logic         last;
	} ie_record_t;

	// Tracks the type/length/value phase the way the parser should, queues the records
	// each accepted byte must produce and checks output words against them in order.
	class ie_record_predictor;
		phase_t      phase;
		logic [7:0]  code;
		logic [7:0]  len;
		logic [7:0]  remain;
		logic [31:0] acc;
		int          pos;
		int          estart;
		ie_record_t  pending_records[$];
		int          words_seen;
		int          errors;

		function new();
			words_seen = 0;
			errors = 0;
			rearm();
		endfunction

		function void rearm();
			phase = PH_TYPE;
			code = 8'd0;
			len = 8'd0;
			remain = 8'd0;
			acc = 32'd0;
			pos = 0;
			estart = 0;
		endfunction

		// code sets as bit masks over codes 0..31; everything else is unknown
		static function kind_t classify(logic [7:0] c);
			logic [31:0] int_set, short_set, byte_set, flag_set, addr_set, text_set;
			int_set   = 32'h8800_0300;
			short_set = 32'h0138_5800;
			byte_set  = 32'h0080_0000;
			flag_set  = 32'h0600_0000;
			addr_set  = 32'h0004_0000;
			text_set  = 32'h1043_A4FE;
			if (c > 8'd31) return K_UNKNOWN;
			if (int_set[c[4:0]]) return K_INT;
			if (short_set[c[4:0]]) return K_SHORT;
			if (byte_set[c[4:0]]) return K_BYTE;
			if (flag_set[c[4:0]]) return K_FLAG;
			if (addr_set[c[4:0]]) return K_ADDR;
			if (text_set[c[4:0]]) return K_TEXT;
			return K_UNKNOWN;
		endfunction

		function ie_record_t element_rec();
			ie_record_t r;
			int need;
			int off;
			r.kind = classify(code);
			need = (r.kind == K_INT) ? 4 : (r.kind == K_SHORT) ? 2 : (r.kind == K_BYTE) ? 1 : 0;
			off = estart + HDR_BYTES;
			if (off > POS_MAX)
				off = POS_MAX;
			r.summary = 1'b0;
			r.code = code;
			r.len = len;
			r.offset = 12'(off);
			if (r.kind == K_UNKNOWN)
				r.es = ES_UNKNOWN;
			else if (need != 0 && int'(len) != need)
				r.es = ES_BAD_LEN;
			else
				r.es = ES_OK;
			r.num = (need != 0 && r.es == ES_OK) ? acc : 32'd0;
			r.ms = MS_OK;
			r.last = 1'b0;
			return r;
		endfunction

		function ie_record_t summary_rec(msg_status_t ms);
			ie_record_t r;
			r.summary = 1'b1;
			r.code = 8'd0;
			r.len = 8'd0;
			r.offset = 12'd0;
			r.kind = K_TEXT;
			r.num = 32'd0;
			r.es = ES_OK;
			r.ms = ms;
			r.last = 1'b1;
			return r;
		endfunction

		// one accepted input byte
		function void note_byte(logic [7:0] b, logic fin);
			bit made;
			bit done;
			made = 0;
			done = 0;
			case (phase)
				PH_LEN: begin
					len = b;
					remain = b;
					if (b == 8'd0) begin
						pending_records.push_back(element_rec());
						made = 1;
						done = 1;
						phase = PH_TYPE;
					end else begin
						phase = PH_VALUE;
					end
				end
				PH_VALUE: begin
					acc = {acc[23:0], b};
					remain = remain - 8'd1;
					if (remain == 8'd0) begin
						pending_records.push_back(element_rec());
						made = 1;
						done = 1;
						phase = PH_TYPE;
					end
				end
				default: begin
					code = b;
					len = 8'd0;
					remain = 8'd0;
					acc = 32'd0;
					estart = pos;
					phase = PH_LEN;
					// final byte landing on a type slot
					if (fin) begin
						pending_records.push_back(summary_rec(MS_STRAY));
						made = 1;
					end
				end
			endcase
			if (fin) begin
				if (!made || done)
					pending_records.push_back(summary_rec(done ? MS_OK : MS_OVERRUN));
				rearm();
			end else if (pos < POS_MAX) begin
				pos++;
			end
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			if (errors < MAX_ERR_LINES)
				$display("ERROR word %0d: %s got %0h expected %0h", words_seen, what, got, want);
			errors++;
		endtask

		task check_word(logic [OUT_DATA_W-1:0] d, logic u, logic l);
			ie_record_t w;
			words_seen++;
			if (pending_records.size() == 0) begin
				report("word with no record pending", d[31:0], 32'd0);
			end else begin
				w = pending_records.pop_front();
				if (u !== w.summary) report("is_summary", u, w.summary);
				if (d[7:0] !== w.code) report("ie_code", d[7:0], w.code);
				if (d[15:8] !== w.len) report("ie_length", d[15:8], w.len);
				if (d[27:16] !== w.offset) report("value_offset", d[27:16], w.offset);
				if (d[30:28] !== w.kind) report("value_kind", d[30:28], w.kind);
				if (d[62:31] !== w.num) report("number_value", d[62:31], w.num);
				if (d[64:63] !== w.es) report("elem_status", d[64:63], w.es);
				if (d[66:65] !== w.ms) report("msg_status", d[66:65], w.ms);
				if (d[71:67] !== 5'd0) report("pad bits", d[71:67], 32'd0);
				if (l !== w.last) report("last_of_run", l, w.last);
			end
		endtask

		task flag_missing();
			ie_record_t w;
			while (pending_records.size() != 0) begin
				w = pending_records.pop_front();
				report("record never produced, code", 32'd0, w.code);
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	bit tx_calm = 0;   // stretches with no source idling
	bit rx_calm = 0;   // stretches with no sink stalls
	int quiet_cycles = 0;

	ie_record_predictor sb = new();

	tlv_info_element_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// mostly bursty waits, sometimes short, sometimes none
	function automatic int draw_wait(bit calm);
		if (calm)
			return 0;
		case ($urandom_range(0, 3))
			0: return 0;
			1: return $urandom_range(0, 2);
			default: return $urandom_range(0, MAX_WAIT);
		endcase
	endfunction

	// Source side. Valid is left high between back-to-back words, so it only
	// ever gets one nonblocking write per time step.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		if ($urandom_range(0, 59) == 0)
			tx_calm = !tx_calm;
		gap = draw_wait(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);    // junk while idle
			s_tlast <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_msg(input logic [7:0] m[$]);
		foreach (m[i])
			send_byte(m[i], i == m.size() - 1);
	endtask

	task automatic add_elem(ref logic [7:0] m[$], input logic [7:0] code, input int n);
		m.push_back(code);
		m.push_back(8'(n));
		repeat (n) m.push_back(8'($urandom));
	endtask

	// Mostly well-formed messages; about one in ten ends on a stray byte and one in
	// ten is cut short inside its last element.
	task automatic build_random(ref logic [7:0] m[$]);
		int n_el;
		int n;
		int r;
		logic [7:0] code;
		kind_t k;
		m.delete();
		n = 0;
		n_el = $urandom_range(1, 5);
		repeat (n_el) begin
			if ($urandom_range(0, 9) < 7)
				code = 8'($urandom_range(0, 31));
			else
				code = 8'($urandom_range(0, 255));
			k = ie_record_predictor::classify(code);
			case (k)
				K_INT: n = 4;
				K_SHORT: n = 2;
				K_BYTE: n = 1;
				default: n = $urandom_range(0, 6);
			endcase
			r = $urandom_range(0, 39);
			if (r == 0)
				n = $urandom_range(9, 255);
			else if (r < 8)
				n = $urandom_range(0, 8);
			add_elem(m, code, n);
		end
		r = $urandom_range(0, 9);
		if (r == 0) begin
			m.push_back(8'($urandom));
		end else if (r == 1) begin
			repeat ($urandom_range(1, n + 1)) void'(m.pop_back());
		end
	endtask

	// Sink side: each word waits a freshly drawn stall before ready goes high.
	initial begin : sink
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
			stall = draw_wait(rx_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Monitor and watchdog. Inputs change only through nonblocking writes, so the
	// values seen here are the ones present at the edge.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_byte(s_tdata, s_tlast);
		if (m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tuser, m_tlast);
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stim
		logic [7:0] msg[$];
		int sent;
		sent = 0;
		wait (arst_n);
		@(posedge clk);

		// int32 of extreme bytes, then short16 ending the message on its last value byte
		msg = '{8'd8, 8'd4, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'd11, 8'd2, 8'h12, 8'h34};
		send_msg(msg);
		// single byte message: stray trailing byte
		msg = '{8'hFF};
		send_msg(msg);
		// unknown code zero, zero length, message ends on the length byte
		msg = '{8'd0, 8'd0};
		send_msg(msg);
		// byte, empty flag, short int32, long int32, unknown; ends on a type byte
		msg = '{8'd23, 8'd1, 8'h80, 8'd25, 8'd0, 8'd9, 8'd3, 8'h01, 8'h02, 8'h03,
			8'd31, 8'd5, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h7F, 8'd30, 8'd0, 8'd1};
		send_msg(msg);
		// overrun inside the value, then overrun on the length byte
		msg = '{8'd1, 8'd5, 8'h41, 8'h42};
		send_msg(msg);
		msg = '{8'd24, 8'd2};
		send_msg(msg);

		while (sent < RANDOM_ITEMS) begin
			build_random(msg);
			send_msg(msg);
			sent += msg.size();
		end
		s_tvalid <= 1'b0;

		while (sb.pending_records.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		sb.flag_missing();
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
